FILE: rtl/core/fixed_block_free_list_allocator_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the free list allocator
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Plain property, checked at every rising edge outside reset.
`define FBF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("free list allocator check failed");
// Implication with an antecedent and a consequent in the same cycle.
`define FBF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("free list allocator check failed");
`else
`define FBF_ASSERT(lbl, clk, rst_n, prop)
`define FBF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/fbfla_pkg.sv
// ---------------------------------------------------------------------------
// Free list allocator package
// Sizes, link encoding, command and status codes, and controller states.
// ---------------------------------------------------------------------------
package fbfla_pkg;

  // Pool size and link encoding; a link equal to MAX_CHUNKS means null.
  localparam int unsigned MAX_CHUNKS = 256;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned LINK_W     = 9;
  localparam logic [LINK_W-1:0] NULL_LINK  = LINK_W'(MAX_CHUNKS);
  localparam logic [LINK_W-1:0] NUM_RESET  = LINK_W'(MAX_CHUNKS);

  // Configuration register indexes.
  localparam logic REG_CHUNK_LIMIT = 1'b0;

  // Command codes carried in the input word.
  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_COUNT = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ALLOC,
    S_CNT_RD,
    S_CNT_WAIT
  } state_t;

endpackage

FILE: rtl/core/fixed_block_free_list_allocator_unit.sv
// ---------------------------------------------------------------------------
// Fixed block free list allocator
// Keeps a pool of fixed-size chunks on a singly linked free list held in a
// single-port-write, registered-read link memory.
// ---------------------------------------------------------------------------
// Usage: commands arrive as words on the in_ channel, the command code in
// in_tuser and the chunk index in in_tdata. Every command gives exactly one
// word on the out_ channel: allocated chunk and free count in out_tdata, the
// status in out_tuser. The pool size is set through the cfg_ register port
// while the block is idle.
// Command steps: alloc does one link memory read, free one link write, and
// an empty alloc or range error neither; init accepts the command, then
// writes one link per cycle over the N active chunks; count walks the list
// of length L, each link costing a memory read and a wait for the
// registered read data.
// The block works on one command at a time; the output register lets it take
// a new command in the same cycle that the previous result is taken.
// Reset empties the list (head null) and sets the pool size to 256; the link
// memory is not cleared, since only entries written by init or free are ever
// followed. When the receiver stalls the result word holds in the output
// register and no new command is accepted until it is taken.
// ---------------------------------------------------------------------------
module fixed_block_free_list_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Command channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] chunk_in
  input  logic [1:0]  in_tuser,     // [1:0] func
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [7:0] chunk_out, [16:8] free_count, rest zero
  output logic [1:0]  out_tuser,    // [1:0] status
  // Register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fbfla_pkg::*;

  `include "fixed_block_free_list_allocator_unit_macros.svh"

  // Register and control state
  logic [LINK_W-1:0] chunk_limit_r;
  state_t            state_r, state_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [LINK_W-1:0] cur_r, cur_nxt;
  logic [LINK_W-1:0] cnt_r, cnt_nxt;

  // Output register
  logic              out_valid_r;
  logic [IDX_W-1:0]  chunk_out_r;
  status_t           status_r;
  logic [LINK_W-1:0] count_r;

  // Result load from the controller
  logic              res_load;
  logic [IDX_W-1:0]  res_chunk;
  status_t           res_status;
  logic [LINK_W-1:0] res_count;

  // Link memory access
  logic [LINK_W-1:0] link_mem [MAX_CHUNKS];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [LINK_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [LINK_W-1:0] rd_q;

  logic              cfg_wr;
  logic              in_acc;
  logic [LINK_W-1:0] n_act;
  logic [LINK_W-1:0] idx_inc;
  cmd_t              in_cmd;

  // Register port: always ready, one register at word index zero.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_limit_r <= NUM_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_CHUNK_LIMIT)) begin
      chunk_limit_r <= cfg_pwdata[LINK_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_CHUNK_LIMIT) ?
                      {{(32-LINK_W){1'b0}}, chunk_limit_r} : 32'd0;

  // Active chunk count: zero acts as one, values above the pool size clamp.
  always_comb begin
    if (chunk_limit_r == '0) begin
      n_act = LINK_W'(1);
    end else if (chunk_limit_r > NULL_LINK) begin
      n_act = NULL_LINK;
    end else begin
      n_act = chunk_limit_r;
    end
  end

  // Handshake on the command side.
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign in_cmd    = cmd_t'(in_tuser);
  assign idx_inc   = {1'b0, idx_r} + LINK_W'(1);

  // Controller state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= NULL_LINK;
      idx_r   <= '0;
      cur_r   <= NULL_LINK;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      idx_r   <= idx_nxt;
      cur_r   <= cur_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state, memory accesses and result load.
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    idx_nxt    = idx_r;
    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = NULL_LINK;
    mem_re     = 1'b0;
    mem_raddr  = head_r[IDX_W-1:0];
    res_load   = 1'b0;
    res_chunk  = '0;
    res_status = ST_OK;
    res_count  = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_INIT: begin
              idx_nxt   = '0;
              state_nxt = S_INIT;
            end
            CMD_ALLOC: begin
              if (head_r[LINK_W-1]) begin
                res_load   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r[IDX_W-1:0];
                state_nxt = S_ALLOC;
              end
            end
            CMD_FREE: begin
              res_load = 1'b1;
              if ({1'b0, in_tdata} >= n_act) begin
                res_status = ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = in_tdata;
                mem_wdata = head_r;
                head_nxt  = {1'b0, in_tdata};
              end
            end
            default: begin
              cur_nxt   = head_r;
              cnt_nxt   = '0;
              state_nxt = S_CNT_RD;
            end
          endcase
        end
      end
      // Chain one link per cycle; the last active chunk ends the list.
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        if (idx_inc == n_act) begin
          mem_wdata = NULL_LINK;
          head_nxt  = '0;
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          mem_wdata = idx_inc;
          idx_nxt   = idx_inc[IDX_W-1:0];
        end
      end
      // Link of the old head is now on the read port.
      S_ALLOC: begin
        res_load  = 1'b1;
        res_chunk = head_r[IDX_W-1:0];
        head_nxt  = rd_q;
        state_nxt = S_IDLE;
      end
      // Walk the list, saturating at MAX_CHUNKS on a looped list.
      S_CNT_RD: begin
        if (cur_r[LINK_W-1] || (cnt_r == NULL_LINK)) begin
          res_load  = 1'b1;
          res_count = cnt_r;
          state_nxt = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cur_r[IDX_W-1:0];
          cnt_nxt   = cnt_r + LINK_W'(1);
          state_nxt = S_CNT_WAIT;
        end
      end
      S_CNT_WAIT: begin
        cur_nxt   = rd_q;
        state_nxt = S_CNT_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Link memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= link_mem[mem_raddr];
    end
  end

  // Output register: holds the result word until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      chunk_out_r <= res_chunk;
      status_r    <= res_status;
      count_r     <= res_count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(24-LINK_W-IDX_W){1'b0}}, count_r, chunk_out_r};
  assign out_tuser  = status_r;

  // Checks on the controller.
  `FBF_ASSERT_IMP(a_no_overwrite, clk, rst_n, res_load, (!out_valid_r || out_tready))
  `FBF_ASSERT_IMP(a_head_null_code, clk, rst_n, head_r[LINK_W-1], (head_r == NULL_LINK))
  `FBF_ASSERT_IMP(a_init_in_range, clk, rst_n, (state_r == S_INIT), ({1'b0, idx_r} < n_act))
  `FBF_ASSERT(a_count_bound, clk, rst_n, (cnt_r <= NULL_LINK))
  `FBF_ASSERT_IMP(a_one_access, clk, rst_n, mem_we, !mem_re)

endmodule
